>>> hw/rtl/bdef_pkg.sv
// Shared types and constants of the box derivative edge finder.
`timescale 1ns / 1ps

package bdef_pkg;

    // Field and register widths fixed by the item and register layout
    localparam int SAMPLE_W    = 8;
    localparam int INDEX_W     = 16;
    localparam int MIN_DIFF_W  = 19;
    localparam int WINDOW_W    = 10;
    localparam int THRESH_W    = 18;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 18;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 1'b1;

    // Reset values
    localparam int WINDOW_RESET = 700;
    localparam int THRESH_RESET = 1387;
    localparam int BEST_RESET   = 262143;

    // One ring step handed from the sequencer to the window tracker
    typedef struct packed {
        logic                       valid;
        logic                       lead;   // sample leaves forward window
        logic                       trail;  // sample leaves backward window
        logic                       eval;   // difference is defined at this step
        logic [INDEX_W-1:0]         pos;    // window boundary position k
        logic signed [SAMPLE_W-1:0] x;
    } bdef_step_t;

endpackage

>>> hw/rtl/bdef_track.sv
// Window sums, difference and running minimum of the edge finder.
`timescale 1ns / 1ps

module bdef_track #(
    parameter int SUM_W  = 18,
    parameter int DIFF_W = 19
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bdef_pkg::bdef_step_t                 step,
    input  logic signed [bdef_pkg::SAMPLE_W-1:0] rd_lead,
    input  logic signed [bdef_pkg::SAMPLE_W-1:0] rd_trail,
    input  logic                                 clear,
    output logic signed [DIFF_W-1:0]             best_diff,
    output logic [bdef_pkg::INDEX_W-1:0]         best_pos,
    output logic                                 busy
);
    import bdef_pkg::*;

    localparam logic signed [DIFF_W-1:0] BEST_INIT = DIFF_W'(BEST_RESET);

    logic signed [SUM_W-1:0]    fwd_reg, fwd_next;
    logic signed [SUM_W-1:0]    bwd_reg, bwd_next;
    logic signed [SAMPLE_W-1:0] lead_val, trail_val;
    logic                       v1_reg, e1_reg;
    logic [INDEX_W-1:0]         pos1_reg;
    logic                       v2_reg, e2_reg;
    logic [INDEX_W-1:0]         pos2_reg;
    logic signed [DIFF_W-1:0]   d_reg, d_next;
    logic signed [DIFF_W-1:0]   best_reg;
    logic [INDEX_W-1:0]         bpos_reg;

    // Stage 1: slide both windows by one sample
    always_comb
    begin
        lead_val  = step.lead  ? rd_lead  : '0;
        trail_val = step.trail ? rd_trail : '0;
        fwd_next  = fwd_reg + SUM_W'(step.x) - SUM_W'(lead_val);
        bwd_next  = bwd_reg + SUM_W'(lead_val) - SUM_W'(trail_val);
        d_next    = DIFF_W'(fwd_reg) - DIFF_W'(bwd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg  <= '0;
            bwd_reg  <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            best_reg <= BEST_INIT;
            bpos_reg <= '0;
        end
        else if (clear)
        begin
            fwd_reg  <= '0;
            bwd_reg  <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            best_reg <= BEST_INIT;
            bpos_reg <= '0;
        end
        else
        begin
            if (step.valid)
            begin
                fwd_reg <= fwd_next;
                bwd_reg <= bwd_next;
            end
            v1_reg <= step.valid;
            // Stage 2 carries the difference; stage 3 keeps the first minimum
            v2_reg <= v1_reg;
            if (v2_reg && e2_reg && (d_reg < best_reg))
            begin
                best_reg <= d_reg;
                bpos_reg <= pos2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg   <= step.eval;
        pos1_reg <= step.pos;
        e2_reg   <= e1_reg;
        pos2_reg <= pos1_reg;
        d_reg    <= d_next;
    end

    assign best_diff = best_reg;
    assign best_pos  = bpos_reg;
    assign busy      = v1_reg | v2_reg;

endmodule

>>> hw/rtl/box_derivative_edge_finder_unit.sv
// Top level of the box derivative falling-edge finder.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                         Handshake
// s_axis    in   tdata[7:0] sample, tlast last_sample            tvalid/tready
// m_axis    out  tdata: edge_found, edge_index, min_difference  tvalid/tready
// cfg       in   cfg_addr index, cfg_wdata value                 cfg_we, no wait
//
// Samples stream in one per cycle for the whole record. After the item with
// tlast the sequencer feeds N-1 zero samples through the ring (N = window),
// then waits for the sum/difference/minimum pipeline to empty. The result sits
// in an output register, so the next record starts while it waits; a second
// result stalls at the end of its record until the first is taken.
// Reset clears the sums, minimum, position and sequencer; the sample ring
// holds no reset and is only read where it has been written in the record.

module box_derivative_edge_finder_unit #(
    parameter int MAX_WINDOW = 1023,
    parameter int MAX_RECORD = 65536
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // tdata: sample[7:0]
    input  logic [bdef_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
    input  logic                                    s_axis_tlast,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: edge_found[0], edge_index[16:1], min_difference[35:17], zero pad
    output logic [bdef_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    cfg_we,
    input  logic [bdef_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [bdef_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
    import bdef_pkg::*;

    localparam int NW     = $clog2(MAX_WINDOW + 1);
    localparam int CW     = (NW > WINDOW_W) ? NW : WINDOW_W;
    localparam int PW     = $clog2(MAX_RECORD + MAX_WINDOW + 1);
    localparam int EW     = (PW > INDEX_W) ? PW : INDEX_W;
    localparam int AW     = $clog2(2 * MAX_WINDOW + 2);
    localparam int DEPTH  = 1 << AW;
    localparam int SUM_W  = $clog2(MAX_WINDOW * 128 + 1) + 1;
    localparam int DIFF_W = (SUM_W + 1 > MIN_DIFF_W) ? SUM_W + 1 : MIN_DIFF_W;
    localparam int FW     = DIFF_W + 1;
    localparam int N_INIT = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // Configuration
    logic [WINDOW_W-1:0] window_reg;
    logic [THRESH_W-1:0] thresh_reg;

    // Sequencer
    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] fl_reg, fl_next;

    logic [CW-1:0] wp_ext;
    logic [NW-1:0] n_clamp, n_use;
    logic          in_acc, first_item, load;

    // Step forming
    logic                       inj_valid;
    logic signed [SAMPLE_W-1:0] inj_x;
    logic [PW-1:0]              n_pw, two_n, lead_addr, trail_addr;
    logic [PW:0]                pos_inc;
    logic [EW-1:0]              epos_full;
    bdef_step_t                 step_next, p0_reg;

    // Sample ring, one write and two registered reads per cycle
    logic [SAMPLE_W-1:0]        ring_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_lead_reg, rd_trail_reg;

    // Tracker and result
    logic signed [DIFF_W-1:0]   best_diff;
    logic [INDEX_W-1:0]         best_pos;
    logic                       trk_busy;
    logic [FW-1:0]              margin;
    logic                       found;
    logic                       out_valid_reg;
    logic [OUT_TDATA_W-1:0]     out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_W'(WINDOW_RESET);
            thresh_reg <= THRESH_W'(THRESH_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_WINDOW:    window_reg <= cfg_wdata[WINDOW_W-1:0];
                REG_THRESHOLD: thresh_reg <= cfg_wdata[THRESH_W-1:0];
                default:       ;
            endcase
        end
    end

    // Window length is clamped to 1..MAX_WINDOW and latched at record start
    always_comb
    begin
        wp_ext = CW'(window_reg);
        if (wp_ext == '0)
            n_clamp = NW'(1);
        else if (wp_ext > CW'(MAX_WINDOW))
            n_clamp = NW'(MAX_WINDOW);
        else
            n_clamp = NW'(wp_ext);
    end

    assign s_axis_tready = (state_reg == ST_RUN);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign first_item    = (pos_reg == '0);
    assign n_use         = (state_reg == ST_RUN && first_item) ? n_clamp : n_reg;
    assign load          = (state_reg == ST_DRAIN) && !p0_reg.valid && !trk_busy
                           && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        n_next     = n_reg;
        fl_next    = fl_reg;
        inj_valid  = 1'b0;
        inj_x      = '0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (in_acc)
                begin
                    if (first_item)
                        n_next = n_clamp;
                    // Samples past the record limit are dropped
                    if (pos_reg < PW'(MAX_RECORD))
                    begin
                        inj_valid = 1'b1;
                        inj_x     = s_axis_tdata[SAMPLE_W-1:0];
                        pos_next  = pos_reg + PW'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        if (n_use > NW'(1))
                        begin
                            fl_next    = n_use - NW'(1);
                            state_next = ST_FLUSH;
                        end
                        else
                            state_next = ST_DRAIN;
                    end
                end
            end
            ST_FLUSH:
            begin
                inj_valid = 1'b1;
                pos_next  = pos_reg + PW'(1);
                fl_next   = fl_reg - NW'(1);
                if (fl_reg == NW'(1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (load)
                begin
                    pos_next   = '0;
                    state_next = ST_RUN;
                end
            end
            default:
                state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            pos_reg   <= '0;
            n_reg     <= NW'(N_INIT);
            fl_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            n_reg     <= n_next;
            fl_reg    <= fl_next;
        end
    end

    // Ring addresses of the samples leaving each window, plus window flags
    always_comb
    begin
        n_pw       = PW'(n_use);
        two_n      = PW'({n_use, 1'b0});
        lead_addr  = pos_reg - n_pw;
        trail_addr = pos_reg - two_n;
        pos_inc    = (PW + 1)'(pos_reg) + (PW + 1)'(1);
        epos_full  = EW'(pos_reg) + EW'(1) - EW'(n_use);

        step_next.valid = inj_valid;
        step_next.lead  = (pos_reg >= n_pw);
        step_next.trail = (pos_reg >= two_n);
        step_next.eval  = (pos_inc >= (PW + 1)'(n_use));
        step_next.pos   = epos_full[INDEX_W-1:0];
        step_next.x     = inj_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_reg <= '0;
        else
            p0_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        if (inj_valid)
            ring_mem[pos_reg[AW-1:0]] <= inj_x;
        rd_lead_reg  <= ring_mem[lead_addr[AW-1:0]];
        rd_trail_reg <= ring_mem[trail_addr[AW-1:0]];
    end

    bdef_track #(
        .SUM_W  (SUM_W),
        .DIFF_W (DIFF_W)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (p0_reg),
        .rd_lead   (rd_lead_reg),
        .rd_trail  (rd_trail_reg),
        .clear     (load),
        .best_diff (best_diff),
        .best_pos  (best_pos),
        .busy      (trk_busy)
    );

    // Edge when min difference + threshold is negative
    assign margin = FW'(best_diff) + FW'(thresh_reg);
    assign found  = margin[FW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= {(OUT_TDATA_W - 1 - INDEX_W - MIN_DIFF_W)'(0),
                             best_diff[MIN_DIFF_W-1:0],
                             found ? best_pos : INDEX_W'(0),
                             found};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Result is taken only after every step has reached the minimum tracker
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!p0_reg.valid && !trk_busy))
        else $error("result loaded with steps in flight");

    // Flushing injects a zero step into the ring every cycle
    a_flush_inject: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |=> (p0_reg.valid && p0_reg.x == '0))
        else $error("flush cycle without a zero step");

    // Record position saturates while samples are taken
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (pos_reg <= PW'(MAX_RECORD)))
        else $error("record position past its limit");

    // A record always starts from a cleared position after a result
    a_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (pos_reg == '0 && out_valid_reg))
        else $error("record state not cleared after result");

endmodule
